### hw/rtl/dpq_pkg.sv
`default_nettype none
package dpq_pkg;

  localparam int DATA_W = 32;
  localparam int CNT_W = 11;
  localparam int DEFAULT_CAPACITY = 1024;
  localparam int S_TDATA_W = 32;
  localparam int M_TDATA_W = 112;

  typedef enum logic [1:0] {
    OP_INSERT  = 2'd0,
    OP_EXT_MIN = 2'd1,
    OP_EXT_MAX = 2'd2,
    OP_CLEAR   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_RSVD  = 2'd3
  } status_t;

  // one interval-heap node: low end and high end of the interval
  typedef struct packed {
    logic [DATA_W-1:0] hi;
    logic [DATA_W-1:0] lo;
  } node_t;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } mem_ctl_t;

  // side: 0 works on the low ends (minimum), 1 on the high ends (maximum)
  function automatic logic [DATA_W-1:0] near_of(input logic side, input node_t w);
    near_of = side ? w.hi : w.lo;
  endfunction

  function automatic logic [DATA_W-1:0] far_of(input logic side, input node_t w);
    far_of = side ? w.lo : w.hi;
  endfunction

  function automatic node_t pack_node(input logic side, input logic [DATA_W-1:0] nr,
                                      input logic [DATA_W-1:0] fr);
    node_t w;
    w.hi = side ? nr : fr;
    w.lo = side ? fr : nr;
    pack_node = w;
  endfunction

  // a ranks ahead of b on the given side
  function automatic logic better(input logic side, input logic [DATA_W-1:0] a,
                                  input logic [DATA_W-1:0] b);
    better = side ? ($signed(a) > $signed(b)) : ($signed(a) < $signed(b));
  endfunction

endpackage
`default_nettype wire

### hw/rtl/dpq_mem.sv
`default_nettype none
module dpq_mem #(
  parameter int DEPTH = 512,
  parameter int AW = 9
) (
  input  wire logic               clk,
  input  wire dpq_pkg::mem_ctl_t  ctl,
  input  wire logic [AW-1:0]      rd_addr,
  input  wire logic [AW-1:0]      wr_addr,
  input  wire dpq_pkg::node_t     wr_data,
  output dpq_pkg::node_t          rd_data
);

  dpq_pkg::node_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (ctl.rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

### hw/rtl/dpq_engine.sv
`default_nettype none
module dpq_engine #(
  parameter int CAPACITY = dpq_pkg::DEFAULT_CAPACITY
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  input  wire dpq_pkg::op_t                op,
  input  wire logic [dpq_pkg::DATA_W-1:0]  item_value,
  output logic                             idle,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [dpq_pkg::DATA_W-1:0]       taken_value,
  output dpq_pkg::status_t                 status,
  output logic [dpq_pkg::CNT_W-1:0]        held_count,
  output logic [dpq_pkg::DATA_W-1:0]       least_value,
  output logic [dpq_pkg::DATA_W-1:0]       greatest_value,
  output logic                             is_empty
);

  localparam int NODES = (CAPACITY + 1) / 2;
  localparam int AW = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int DW = dpq_pkg::DATA_W;

  typedef enum logic [10:0] {
    S_IDLE     = 11'b00000000001,
    S_UP_START = 11'b00000000010,
    S_UP_CMP   = 11'b00000000100,
    S_INS_LAST = 11'b00000001000,
    S_EXT_ROOT = 11'b00000010000,
    S_EXT_LAST = 11'b00000100000,
    S_SD_A     = 11'b00001000000,
    S_SD_B     = 11'b00010000000,
    S_SD_C     = 11'b00100000000,
    S_FIN      = 11'b01000000000,
    S_FIN_RD   = 11'b10000000000
  } state_t;

  state_t st, st_next;
  logic [CW-1:0] n, n_next;
  logic [CW-1:0] k, k_next;
  dpq_pkg::node_t cur, cur_next;
  dpq_pkg::node_t c1w, c1w_next;
  logic [DW-1:0] val, val_next;
  logic [DW-1:0] taken, taken_next;
  dpq_pkg::status_t stat, stat_next;
  logic side, side_next;
  logic pick, pick_next;
  logic single_up, single_up_next;
  logic has2, has2_next;

  dpq_pkg::mem_ctl_t ctl;
  logic [CW:0] rd_idx, wr_idx;
  dpq_pkg::node_t wr_data, rd;

  logic [CW:0] nodes, c1, c2, chi;
  logic [CW-1:0] parent;
  logic k_single, side_e, mv, use2, ch_single;
  logic [DW-1:0] up_x;
  dpq_pkg::node_t ch, fin_w, up_w;

  dpq_mem #(.DEPTH(NODES), .AW(AW)) u_mem (
    .clk     (clk),
    .ctl     (ctl),
    .rd_addr (rd_idx[AW-1:0]),
    .wr_addr (wr_idx[AW-1:0]),
    .wr_data (wr_data),
    .rd_data (rd)
  );

  always_comb begin
    nodes     = ({1'b0, n} + (CW+1)'(1)) >> 1;
    c1        = {k, 1'b1};
    c2        = {k, 1'b0} + (CW+1)'(2);
    parent    = CW'((k - CW'(1)) >> 1);
    k_single  = ({1'b0, k} == nodes - (CW+1)'(1)) && n[0];
    side_e    = pick ? !dpq_pkg::better(1'b0, val, rd.lo) : side;
    mv        = dpq_pkg::better(side_e, val, dpq_pkg::near_of(side_e, rd));
    up_x      = mv ? dpq_pkg::near_of(side_e, rd) : val;
    up_w      = single_up ? '{hi: up_x, lo: up_x}
                          : dpq_pkg::pack_node(side_e, up_x, dpq_pkg::far_of(side_e, cur));
    use2      = has2 && dpq_pkg::better(side, dpq_pkg::near_of(side, rd),
                                        dpq_pkg::near_of(side, c1w));
    ch        = use2 ? rd : c1w;
    chi       = use2 ? c2 : c1;
    ch_single = (chi == nodes - (CW+1)'(1)) && n[0];
    if (k_single) begin
      fin_w = '{hi: val, lo: val};
    end else if (dpq_pkg::better(side, dpq_pkg::far_of(side, cur), val)) begin
      fin_w = dpq_pkg::pack_node(side, dpq_pkg::far_of(side, cur), val);
    end else begin
      fin_w = dpq_pkg::pack_node(side, val, dpq_pkg::far_of(side, cur));
    end
  end

  always_comb begin
    st_next        = st;
    n_next         = n;
    k_next         = k;
    cur_next       = cur;
    c1w_next       = c1w;
    val_next       = val;
    taken_next     = taken;
    stat_next      = stat;
    side_next      = side;
    pick_next      = pick;
    single_up_next = single_up;
    has2_next      = has2;
    ctl            = '0;
    rd_idx         = '0;
    wr_idx         = {1'b0, k};
    wr_data        = fin_w;
    unique case (st)
      S_IDLE: begin
        if (start) begin
          val_next   = item_value;
          taken_next = '0;
          stat_next  = dpq_pkg::ST_OK;
          side_next  = (op == dpq_pkg::OP_EXT_MAX);
          case (op)
            dpq_pkg::OP_INSERT: begin
              if (n == CW'(CAPACITY)) begin
                stat_next = dpq_pkg::ST_FULL;
                st_next   = S_FIN;
              end else begin
                n_next = n + CW'(1);
                k_next = n >> 1;
                if (n[0]) begin
                  ctl.rd_en = 1'b1;
                  rd_idx    = {1'b0, n >> 1};
                  st_next   = S_INS_LAST;
                end else begin
                  single_up_next = 1'b1;
                  pick_next      = 1'b1;
                  st_next        = S_UP_START;
                end
              end
            end
            dpq_pkg::OP_EXT_MIN, dpq_pkg::OP_EXT_MAX: begin
              if (n == '0) begin
                stat_next = dpq_pkg::ST_EMPTY;
                st_next   = S_FIN;
              end else begin
                n_next    = n - CW'(1);
                ctl.rd_en = 1'b1;
                st_next   = S_EXT_ROOT;
              end
            end
            default: begin
              n_next  = '0;
              st_next = S_FIN;
            end
          endcase
        end
      end
      S_INS_LAST: begin
        // far end of either side is the old single value
        cur_next       = '{hi: rd.lo, lo: rd.lo};
        side_next      = !dpq_pkg::better(1'b0, val, rd.lo);
        single_up_next = 1'b0;
        pick_next      = 1'b0;
        st_next        = S_UP_START;
      end
      S_UP_START: begin
        if (k == '0) begin
          ctl.wr_en = 1'b1;
          wr_data   = single_up ? '{hi: val, lo: val}
                                : dpq_pkg::pack_node(side, val, dpq_pkg::far_of(side, cur));
          st_next   = S_FIN;
        end else begin
          ctl.rd_en = 1'b1;
          rd_idx    = {1'b0, parent};
          st_next   = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        ctl.wr_en = 1'b1;
        wr_data   = up_w;
        if (mv) begin
          k_next         = parent;
          cur_next       = rd;
          side_next      = side_e;
          pick_next      = 1'b0;
          single_up_next = 1'b0;
          st_next        = S_UP_START;
        end else begin
          st_next = S_FIN;
        end
      end
      S_EXT_ROOT: begin
        taken_next = dpq_pkg::near_of(side, rd);
        cur_next   = rd;
        if (n == '0) begin
          st_next = S_FIN;
        end else begin
          ctl.rd_en = 1'b1;
          rd_idx    = {1'b0, n >> 1};
          st_next   = S_EXT_LAST;
        end
      end
      S_EXT_LAST: begin
        if (n == CW'(1)) begin
          ctl.wr_en = 1'b1;
          wr_idx    = '0;
          wr_data   = '{hi: dpq_pkg::far_of(side, cur), lo: dpq_pkg::far_of(side, cur)};
          st_next   = S_FIN;
        end else begin
          // pull one value off the last node, then sift it down from the root
          if (!n[0]) begin
            val_next = rd.lo;
          end else begin
            val_next  = dpq_pkg::near_of(side, rd);
            ctl.wr_en = 1'b1;
            wr_idx    = {1'b0, n >> 1};
            wr_data   = '{hi: dpq_pkg::far_of(side, rd), lo: dpq_pkg::far_of(side, rd)};
          end
          k_next  = '0;
          st_next = S_SD_A;
        end
      end
      S_SD_A: begin
        if (c1 >= nodes) begin
          ctl.wr_en = 1'b1;
          st_next   = S_FIN;
        end else begin
          ctl.rd_en = 1'b1;
          rd_idx    = c1;
          st_next   = S_SD_B;
        end
      end
      S_SD_B: begin
        c1w_next = rd;
        if (c2 < nodes) begin
          ctl.rd_en = 1'b1;
          rd_idx    = c2;
          has2_next = 1'b1;
        end else begin
          has2_next = 1'b0;
        end
        st_next = S_SD_C;
      end
      S_SD_C: begin
        ctl.wr_en = 1'b1;
        if (dpq_pkg::better(side, dpq_pkg::near_of(side, ch), val)) begin
          wr_data = dpq_pkg::pack_node(side, dpq_pkg::near_of(side, ch),
                                       dpq_pkg::far_of(side, cur));
          k_next  = CW'(chi);
          if (!ch_single && dpq_pkg::better(side, dpq_pkg::far_of(side, ch), val)) begin
            val_next = dpq_pkg::far_of(side, ch);
            cur_next = dpq_pkg::pack_node(side, dpq_pkg::near_of(side, ch), val);
          end else begin
            cur_next = ch;
          end
          st_next = S_SD_A;
        end else begin
          st_next = S_FIN;
        end
      end
      S_FIN: begin
        ctl.rd_en = 1'b1;
        st_next   = S_FIN_RD;
      end
      S_FIN_RD: begin
        if (!out_valid || out_ready) begin
          st_next = S_IDLE;
        end
      end
      default: st_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= S_IDLE;
      n         <= '0;
      out_valid <= 1'b0;
    end else begin
      st <= st_next;
      n  <= n_next;
      if (st == S_FIN_RD && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    k         <= k_next;
    cur       <= cur_next;
    c1w       <= c1w_next;
    val       <= val_next;
    taken     <= taken_next;
    stat      <= stat_next;
    side      <= side_next;
    pick      <= pick_next;
    single_up <= single_up_next;
    has2      <= has2_next;
    if (st == S_FIN_RD && (!out_valid || out_ready)) begin
      taken_value    <= taken;
      status         <= stat;
      held_count     <= dpq_pkg::CNT_W'(n);
      least_value    <= (n == '0) ? '0 : rd.lo;
      greatest_value <= (n == '0) ? '0 : rd.hi;
      is_empty       <= (n == '0);
    end
  end

  assign idle = (st == S_IDLE);

endmodule
`default_nettype wire

### hw/rtl/double_ended_priority_queue.sv
`default_nettype none
// Double-ended priority queue of up to CAPACITY signed 32-bit values, kept as an
// interval heap in one single-port-read memory of (CAPACITY+1)/2 nodes, each node
// holding a low and a high end. Each transfer in gives one transfer out with the
// extracted value, status, count and the current minimum and maximum. Items are
// handled one at a time: insert climbs from the new leaf toward the root, extract
// moves a value of the last node to the root and sifts it down, and clear and the
// error cases go straight to the result. A new item is taken while a result
// still waits on the output side. No clearing pass is needed after reset.
module double_ended_priority_queue #(
  parameter int CAPACITY = dpq_pkg::DEFAULT_CAPACITY
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            s_tvalid,
  output logic                                 s_tready,
  input  wire logic [dpq_pkg::S_TDATA_W-1:0]   s_tdata,   // [31:0] item_value
  input  wire logic [1:0]                      s_tuser,   // [1:0] op
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  // [31:0] taken_value, [42:32] held_count, [74:43] least_value,
  // [106:75] greatest_value, [111:107] zero
  output logic [dpq_pkg::M_TDATA_W-1:0]        m_tdata,
  output logic [2:0]                           m_tuser    // [1:0] status, [2] is_empty
);

  logic idle;
  logic [dpq_pkg::DATA_W-1:0] taken_value, least_value, greatest_value;
  dpq_pkg::status_t status;
  logic [dpq_pkg::CNT_W-1:0] held_count;
  logic is_empty;

  dpq_engine #(.CAPACITY(CAPACITY)) u_engine (
    .clk            (clk),
    .rst            (rst),
    .start          (s_tvalid && idle),
    .op             (dpq_pkg::op_t'(s_tuser)),
    .item_value     (s_tdata[dpq_pkg::DATA_W-1:0]),
    .idle           (idle),
    .out_valid      (m_tvalid),
    .out_ready      (m_tready),
    .taken_value    (taken_value),
    .status         (status),
    .held_count     (held_count),
    .least_value    (least_value),
    .greatest_value (greatest_value),
    .is_empty       (is_empty)
  );

  assign s_tready = idle;
  assign m_tdata  = {5'd0, greatest_value, least_value, held_count, taken_value};
  assign m_tuser  = {is_empty, status};

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && is_empty |-> least_value == '0 && greatest_value == '0 && held_count == '0)
    else $error("empty result carries nonzero fields");

  a_order: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !is_empty |-> $signed(least_value) <= $signed(greatest_value))
    else $error("minimum above maximum");

  a_full: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && status == dpq_pkg::ST_FULL |->
      held_count == dpq_pkg::CNT_W'(CAPACITY) && taken_value == '0)
    else $error("full status with wrong count");

  a_underflow: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && status == dpq_pkg::ST_EMPTY |-> is_empty && taken_value == '0)
    else $error("empty status on a nonempty queue");

endmodule
`default_nettype wire

### dv/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import dpq_pkg::*;

  typedef struct {
    logic signed [31:0] taken;
    status_t            st;
    logic [10:0]        cnt;
    logic signed [31:0] least;
    logic signed [31:0] greatest;
    logic               emp;
  } outcome_t;

  typedef struct {
    op_t                op;
    logic signed [31:0] val;
    bit                 typed;
    outcome_t           want;
  } request_t;

  localparam int TAIL = 150;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [31:0]  s_tdata = '0;
  logic [1:0]   s_tuser = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [111:0] m_tdata;
  logic [2:0]   m_tuser;

  request_t           requests[$];
  outcome_t           pending_outcomes[$];
  logic signed [31:0] sorted_values[$];
  request_t           on_bus;
  int                 next_idx = 0;
  int                 sent = 0;
  int                 got = 0;
  int                 errors = 0;
  int                 gap_left = 0;
  int                 stall_left = 0;
  int                 hold_left = 0;
  bit                 pressed = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  double_ended_priority_queue DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  function automatic outcome_t mk_out(logic signed [31:0] taken, status_t st, int cnt,
                                      logic signed [31:0] lo, logic signed [31:0] hi);
    outcome_t o;
    o.taken = taken;
    o.st = st;
    o.cnt = cnt[10:0];
    o.least = lo;
    o.greatest = hi;
    o.emp = (cnt == 0);
    return o;
  endfunction

  function automatic request_t mk_req(op_t op, logic signed [31:0] val, bit typed = 0,
                                      outcome_t want = '{taken: '0, st: ST_OK, cnt: '0,
                                                         least: '0, greatest: '0,
                                                         emp: 1'b0});
    request_t r;
    r.op = op;
    r.val = val;
    r.typed = typed;
    r.want = want;
    return r;
  endfunction

  function automatic logic signed [31:0] rand_value();
    case ($urandom_range(0, 7))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2, 3: return $signed($urandom_range(0, 16)) - 8;
      default: return $urandom;
    endcase
  endfunction

  function automatic op_t rand_op();
    int r;
    r = $urandom_range(0, 99);
    if (r < 47) return OP_INSERT;
    if (r < 73) return OP_EXT_MIN;
    if (r < 98) return OP_EXT_MAX;
    return OP_CLEAR;
  endfunction

  // apply one operation to the sorted multiset and give its result
  function automatic outcome_t apply_op(op_t op, logic signed [31:0] val);
    outcome_t o;
    int pos;
    o.taken = '0;
    o.st = ST_OK;
    case (op)
      OP_INSERT: begin
        if (sorted_values.size() >= DEFAULT_CAPACITY) begin
          o.st = ST_FULL;
        end else begin
          pos = 0;
          while (pos < sorted_values.size() && sorted_values[pos] <= val) pos++;
          sorted_values.insert(pos, val);
        end
      end
      OP_EXT_MIN, OP_EXT_MAX: begin
        if (sorted_values.size() == 0) o.st = ST_EMPTY;
        else if (op == OP_EXT_MIN) o.taken = sorted_values.pop_front();
        else o.taken = sorted_values.pop_back();
      end
      default: sorted_values.delete();
    endcase
    o.cnt = 11'(sorted_values.size());
    o.emp = (sorted_values.size() == 0);
    o.least = o.emp ? '0 : sorted_values[0];
    o.greatest = o.emp ? '0 : sorted_values[$];
    return o;
  endfunction

  initial begin
    outcome_t none;
    none = mk_out(0, ST_EMPTY, 0, 0, 0);
    requests.push_back(mk_req(OP_EXT_MIN, 0, 1, none));
    requests.push_back(mk_req(OP_EXT_MAX, 32'sh1234, 1, none));
    requests.push_back(mk_req(OP_INSERT, 32'sh7fffffff, 1,
                              mk_out(0, ST_OK, 1, 32'sh7fffffff, 32'sh7fffffff)));
    requests.push_back(mk_req(OP_INSERT, 32'sh80000000, 1,
                              mk_out(0, ST_OK, 2, 32'sh80000000, 32'sh7fffffff)));
    requests.push_back(mk_req(OP_INSERT, 0));
    requests.push_back(mk_req(OP_INSERT, -1));
    requests.push_back(mk_req(OP_INSERT, 5));
    requests.push_back(mk_req(OP_INSERT, 5));
    requests.push_back(mk_req(OP_INSERT, 5));
    requests.push_back(mk_req(OP_EXT_MAX, 0));
    requests.push_back(mk_req(OP_EXT_MIN, 0));
    requests.push_back(mk_req(OP_EXT_MAX, 0));
    requests.push_back(mk_req(OP_EXT_MIN, 0));
    requests.push_back(mk_req(OP_CLEAR, 32'shffffffff, 1, mk_out(0, ST_OK, 0, 0, 0)));
    requests.push_back(mk_req(OP_EXT_MAX, 0, 1, none));
    requests.push_back(mk_req(OP_INSERT, 32'sh55555555));
    requests.push_back(mk_req(OP_INSERT, 32'shaaaaaaaa));
    requests.push_back(mk_req(OP_EXT_MIN, 0));
    requests.push_back(mk_req(OP_EXT_MIN, 0));
    requests.push_back(mk_req(OP_CLEAR, 0, 1, mk_out(0, ST_OK, 0, 0, 0)));
    // fill to capacity, overflow it, then drain partly
    for (int i = 0; i < DEFAULT_CAPACITY + 3; i++)
      requests.push_back(mk_req(OP_INSERT, rand_value()));
    for (int i = 0; i < 40; i++)
      requests.push_back(mk_req(($urandom_range(0, 1) != 0) ? OP_EXT_MIN : OP_EXT_MAX, 0));
    requests.push_back(mk_req(OP_CLEAR, 0));
    for (int i = 0; i < 110; i++)
      requests.push_back(mk_req(rand_op(), rand_value()));
  end

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
  end

  // sender
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        outcome_t o;
        o = apply_op(on_bus.op, on_bus.val);
        pending_outcomes.push_back(on_bus.typed ? on_bus.want : o);
        sent++;
      end
      if (s_tvalid && !s_tready) begin
        // hold the offered transfer
      end else if (gap_left > 0) begin
        gap_left--;
        s_tvalid <= 1'b0;
      end else if (next_idx >= requests.size()) begin
        s_tvalid <= 1'b0;
      end else if (next_idx < requests.size() - TAIL && $urandom_range(0, 11) == 0) begin
        gap_left = $urandom_range(1, 19) - 1;
        s_tvalid <= 1'b0;
      end else begin
        on_bus = requests[next_idx];
        next_idx++;
        s_tvalid <= 1'b1;
        s_tdata <= on_bus.val;
        s_tuser <= on_bus.op;
      end
    end
  end

  // receiver and checker
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        outcome_t a, e;
        a.taken = m_tdata[31:0];
        a.cnt = m_tdata[42:32];
        a.least = m_tdata[74:43];
        a.greatest = m_tdata[106:75];
        a.st = status_t'(m_tuser[1:0]);
        a.emp = m_tuser[2];
        got++;
        if (pending_outcomes.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected transfer out at %0t", $realtime);
        end else begin
          e = pending_outcomes.pop_front();
          if (a.taken !== e.taken || a.st !== e.st || a.cnt !== e.cnt ||
              a.least !== e.least || a.greatest !== e.greatest || a.emp !== e.emp ||
              m_tdata[111:107] !== '0) begin
            errors++;
            if (errors <= 10) begin
              $display("mismatch #%0d: exp taken=%0d st=%0d cnt=%0d min=%0d max=%0d emp=%0b",
                       got, e.taken, e.st, e.cnt, e.least, e.greatest, e.emp);
              $display("  got taken=%0d st=%0d cnt=%0d min=%0d max=%0d emp=%0b",
                       a.taken, a.st, a.cnt, a.least, a.greatest, a.emp);
            end
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (!pressed && got == 300) begin
        // long hold-off: let the block back up into its input
        pressed = 1;
        hold_left = 400;
        m_tready <= 1'b0;
      end else if (sent >= requests.size() - TAIL) begin
        m_tready <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else if ($urandom_range(0, 11) == 0) begin
        stall_left = $urandom_range(1, 19) - 1;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  initial begin
    wait (!rst && requests.size() > 0 && sent == requests.size());
    wait (pending_outcomes.size() == 0);
    repeat (60) @(posedge clk);
    if (errors == 0 && pending_outcomes.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
